@@ rtl/ichm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ichm_pkg: shared types and constants of the completion hole merger
// Field widths, configuration register indexes and the records that travel
// between the front end, the work queue and the back end.
// ----------------------------------------------------------------------------
package ichm_pkg;

    localparam int VALUE_W  = 41;  // signed result / preset width
    localparam int LEN_W    = 32;  // piece lengths and offsets
    localparam int CODE_W   = 16;  // error codes
    localparam int PIECE_W  = 12;  // reported piece numbers
    localparam int BYTES_W  = 40;  // saturating byte counts
    localparam int IN_IDX_W = 6;   // request index as carried on the ports
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    // Both queues between the parts hold this many entries
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READ_MODE   = 2'd0,
        CFG_ALLOW_HOLES = 2'd1,
        CFG_HOLE_CODE   = 2'd2
    } t_cfg_index;

    typedef enum logic {
        OP_PRESET = 1'b0,
        OP_PIECE  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic              read_mode;
        logic              allow_holes;
        logic [CODE_W-1:0] hole_code;
    } t_cfg;

    // Classified request as it waits between front and back end
    typedef struct packed {
        t_opcode              op;
        logic [IN_IDX_W-1:0]  idx;
        logic [VALUE_W-1:0]   preset;
        logic                 length_ok;
        logic [LEN_W-1:0]     iolen;      // returned length, zero on error
        logic [LEN_W-1:0]     diff;       // expected minus returned
        logic                 opens;      // piece came back short
        logic                 nonzero;    // piece carried data
        logic                 chunk_missing;
        logic [CODE_W-1:0]    error_code;
    } t_work;

    typedef struct packed {
        logic [IN_IDX_W-1:0] idx;
        logic [VALUE_W-1:0]  value;
        logic                zero_fill;
        logic [PIECE_W-1:0]  first_piece;
        logic [LEN_W-1:0]    first_offset;
        logic [PIECE_W-1:0]  end_piece;
    } t_result;

endpackage

@@ rtl/ichm_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ichm_queue: short first-in first-out buffer
// Holds a few records of any packed type between two parts that stall apart.
// ----------------------------------------------------------------------------
module ichm_queue #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    import ichm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    T                 r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/ichm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ichm_front: request intake and classification
// Folds the request index, works out the returned length, shortfall and
// short-piece flags, and queues the record for the back end.
// ----------------------------------------------------------------------------
module ichm_front #(
    parameter int REQUESTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_opcode,
    input  logic [ichm_pkg::IN_IDX_W-1:0] i_request_index,
    input  logic signed [ichm_pkg::VALUE_W-1:0] i_preset_value,
    input  logic                          i_length_ok,
    input  logic [ichm_pkg::LEN_W-1:0]    i_returned_length,
    input  logic [ichm_pkg::LEN_W-1:0]    i_expected_length,
    input  logic                          i_chunk_missing,
    input  logic [ichm_pkg::CODE_W-1:0]   i_error_code,
    output ichm_pkg::t_work               o_work,
    output logic                          o_empty,
    input  logic                          i_pop
);
    import ichm_pkg::*;

    localparam int IN_SPAN = 2 ** IN_IDX_W;

    t_work            work;
    logic [LEN_W-1:0] iolen;

    // Fold an index into the request range; constant selection, no divider
    function automatic logic [IN_IDX_W-1:0] fold_index(input logic [IN_IDX_W-1:0] v);
        logic [IN_IDX_W-1:0] res;
        res = '0;
        for (int k = 0; k < IN_SPAN; k++) begin
            if (v == IN_IDX_W'(k)) begin
                res = IN_IDX_W'(k % REQUESTS);
            end
        end
        return res;
    endfunction

    assign iolen = i_length_ok ? i_returned_length : '0;

    always_comb begin
        work.op            = t_opcode'(i_opcode);
        work.idx           = fold_index(i_request_index);
        work.preset        = i_preset_value;
        work.length_ok     = i_length_ok;
        work.iolen         = iolen;
        work.diff          = i_expected_length - iolen;
        work.opens         = (iolen < i_expected_length);
        work.nonzero       = (iolen != '0);
        work.chunk_missing = i_chunk_missing;
        work.error_code    = i_error_code;
    end

    ichm_queue #(
        .T (t_work)
    ) u_work_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (work),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (o_work),
        .o_empty (o_empty)
    );

endmodule

@@ rtl/ichm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ichm_back: result update engine
// Two steps per request: decide against the walk state and read the stored
// result, then merge, write back, advance the walk and queue the result.
// ----------------------------------------------------------------------------
module ichm_back #(
    parameter int REQUESTS   = 64,
    parameter int MAX_PIECES = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ichm_pkg::t_cfg    i_cfg,
    input  ichm_pkg::t_work   i_work,
    input  logic              i_work_empty,
    output logic              o_work_pop,
    output ichm_pkg::t_result o_result,
    output logic              o_empty,
    input  logic              i_pop
);
    import ichm_pkg::*;

    localparam int IDX_W = (REQUESTS > 1) ? $clog2(REQUESTS) : 1;
    localparam int PC_W  = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam logic [PC_W-1:0] PC_LAST = PC_W'(MAX_PIECES - 1);
    localparam int SUM_W = VALUE_W + 2;

    typedef enum logic [1:0] {
        SEL_KEEP = 2'd0,   // stored result stands before the length add
        SEL_FILL = 2'd1,   // hole closed: add hole bytes, report fill range
        SEL_CODE = 2'd2,   // hole not allowed: store hole error
        SEL_ERR  = 2'd3    // piece error: latch its code unless already negative
    } t_sel;

    // Result store, undefined until preset
    logic [VALUE_W-1:0]  r_mem [REQUESTS];
    logic [VALUE_W-1:0]  r_rdata;

    // Walk state
    logic                r_prev_vld;
    logic [IN_IDX_W-1:0] r_prev;
    logic [PC_W-1:0]     r_pc;
    logic                r_ho;
    logic                r_hsv;
    logic [PIECE_W-1:0]  r_hsp;
    logic [LEN_W-1:0]    r_hso;
    logic [BYTES_W-1:0]  r_hb;

    // Second step registers
    logic                r_b_vld;
    t_opcode             r_b_op;
    logic [IN_IDX_W-1:0] r_b_idx;
    logic [VALUE_W-1:0]  r_b_preset;
    t_sel                r_b_sel;
    logic [CODE_W-1:0]   r_b_code;
    logic [LEN_W-1:0]    r_b_iolen;
    logic                r_b_opens;
    logic                r_b_ho_mid;
    logic                r_b_hsv_mid;
    logic [BYTES_W-1:0]  r_b_hb_cand;
    logic [BYTES_W:0]    r_b_addb;
    logic [BYTES_W:0]    r_b_addc;

    // First step
    logic                out_full;
    logic                a_go;
    logic                a_same;
    logic                a_merge;
    logic                a_fmode;
    t_sel                a_sel;
    logic                a_ho_mid;
    logic                a_hsv_mid;
    logic [BYTES_W-1:0]  a_base;
    logic [BYTES_W:0]    a_hb_sum;
    logic [BYTES_W:0]    a_addb;
    logic [BYTES_W:0]    a_addc;

    // Second step
    logic [SUM_W-1:0]    b_r_ext;
    logic [SUM_W-1:0]    b_s1;
    logic [SUM_W-1:0]    b_s2;
    logic [SUM_W-1:0]    b_sat2;
    logic [SUM_W-1:0]    b_neg_code;
    logic [SUM_W-1:0]    b_r1;
    logic [SUM_W-1:0]    b_r2;
    logic                b_nonneg;
    logic                b_fill;
    logic [VALUE_W-1:0]  b_value;
    t_result             b_result;

    // Start a request only while no other is mid-update and the result has room
    assign a_go       = !r_b_vld && !i_work_empty && !out_full;
    assign o_work_pop = a_go;

    assign a_same  = r_prev_vld && (r_prev == i_work.idx);
    assign a_merge = i_work.length_ok && i_work.nonzero && r_ho && a_same;
    assign a_fmode = i_cfg.read_mode && i_cfg.allow_holes;

    always_comb begin
        if (i_work.length_ok) begin
            if (a_merge) begin
                a_sel = a_fmode ? SEL_FILL : SEL_CODE;
            end else begin
                a_sel = SEL_KEEP;
            end
        end else if (i_cfg.read_mode && i_work.chunk_missing) begin
            a_sel = SEL_KEEP;
        end else begin
            a_sel = SEL_ERR;
        end
    end

    // Hole tracking after the merge decision, before any new shortfall
    always_comb begin
        if (i_work.length_ok && ((a_merge && a_fmode) || !a_same)) begin
            a_ho_mid  = 1'b0;
            a_hsv_mid = 1'b0;
        end else begin
            a_ho_mid  = r_ho;
            a_hsv_mid = r_hsv;
        end
    end

    assign a_base   = a_hsv_mid ? r_hb : '0;
    assign a_hb_sum = {1'b0, a_base} + {{(BYTES_W + 1 - LEN_W){1'b0}}, i_work.diff};
    assign a_addb   = (a_sel == SEL_FILL) ? {1'b0, r_hb} : '0;
    assign a_addc   = ((a_sel == SEL_FILL) ? {1'b0, r_hb} : '0)
                    + {{(BYTES_W + 1 - LEN_W){1'b0}}, i_work.iolen};

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_rdata     <= r_mem[IDX_W'(i_work.idx)];
            r_b_op      <= i_work.op;
            r_b_idx     <= i_work.idx;
            r_b_preset  <= i_work.preset;
            r_b_sel     <= a_sel;
            r_b_code    <= (a_sel == SEL_CODE) ? i_cfg.hole_code : i_work.error_code;
            r_b_iolen   <= i_work.iolen;
            r_b_opens   <= i_work.opens;
            r_b_ho_mid  <= a_ho_mid;
            r_b_hsv_mid <= a_hsv_mid;
            r_b_hb_cand <= a_hb_sum[BYTES_W] ? BYTES_MAX : a_hb_sum[BYTES_W-1:0];
            r_b_addb    <= a_addb;
            r_b_addc    <= a_addc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= a_go;
        end
    end

    // Merge against the stored result
    assign b_r_ext    = {{(SUM_W - VALUE_W){r_rdata[VALUE_W-1]}}, r_rdata};
    assign b_s1       = b_r_ext + {{(SUM_W - BYTES_W - 1){1'b0}}, r_b_addb};
    assign b_s2       = b_r_ext + {{(SUM_W - BYTES_W - 1){1'b0}}, r_b_addc};
    assign b_sat2     = (b_s2[SUM_W-1:BYTES_W] != '0)
                      ? {{(SUM_W - BYTES_W){1'b0}}, BYTES_MAX} : b_s2;
    assign b_neg_code = '0 - {{(SUM_W - CODE_W){1'b0}}, r_b_code};

    always_comb begin
        unique case (r_b_sel) inside
            SEL_FILL, SEL_KEEP: b_r1 = b_s1;
            SEL_CODE:           b_r1 = b_neg_code;
            SEL_ERR:            b_r1 = r_rdata[VALUE_W-1] ? b_r_ext : b_neg_code;
        endcase
    end

    assign b_nonneg = !b_r1[SUM_W-1];

    always_comb begin
        if (!b_nonneg) begin
            b_r2 = b_r1;
        end else if ((r_b_sel == SEL_FILL) || (r_b_sel == SEL_KEEP)) begin
            b_r2 = b_sat2;
        end else begin
            b_r2 = {{(SUM_W - LEN_W){1'b0}}, r_b_iolen};
        end
    end

    assign b_fill  = (r_b_op == OP_PIECE) && (r_b_sel == SEL_FILL);
    assign b_value = (r_b_op == OP_PRESET) ? r_b_preset : b_r2[VALUE_W-1:0];

    always_comb begin
        b_result.idx          = r_b_idx;
        b_result.value        = b_value;
        b_result.zero_fill    = b_fill;
        b_result.first_piece  = b_fill ? r_hsp : '0;
        b_result.first_offset = b_fill ? r_hso : '0;
        b_result.end_piece    = b_fill ? PIECE_W'(r_pc) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (r_b_vld) begin
            r_mem[IDX_W'(r_b_idx)] <= b_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_vld <= 1'b0;
            r_prev     <= '0;
            r_pc       <= '0;
            r_ho       <= 1'b0;
            r_hsv      <= 1'b1;
            r_hsp      <= '0;
            r_hso      <= '0;
            r_hb       <= '0;
        end else if (r_b_vld) begin
            if (r_b_op == OP_PRESET) begin
                r_prev_vld <= 1'b0;
                r_prev     <= '0;
                r_pc       <= '0;
                r_ho       <= 1'b0;
                r_hsv      <= 1'b1;
                r_hsp      <= '0;
                r_hso      <= '0;
                r_hb       <= '0;
            end else begin
                r_prev_vld <= 1'b1;
                r_prev     <= r_b_idx;
                if (r_pc != PC_LAST) begin
                    r_pc <= r_pc + 1'b1;
                end
                if (b_nonneg && r_b_opens) begin
                    r_ho  <= 1'b1;
                    r_hsv <= 1'b1;
                    r_hb  <= r_b_hb_cand;
                    if (!r_b_hsv_mid) begin
                        r_hsp <= PIECE_W'(r_pc);
                        r_hso <= r_b_iolen;
                    end
                end else begin
                    r_ho  <= r_b_ho_mid;
                    r_hsv <= r_b_hsv_mid;
                end
            end
        end
    end

    ichm_queue #(
        .T (t_result)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_b_vld),
        .i_data  (b_result),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

endmodule

@@ rtl/io_completion_hole_merger.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_completion_hole_merger: per-request completion and hole merger
// Folds piece completions into per-request byte counts, tracks short pieces
// as holes and reports zero-fill ranges or latches hole errors.
// ----------------------------------------------------------------------------
// Requests go in through a queue-like port (push/full) and come back one
// result per request through another (empty/pop), oldest first. A preset
// loads a request's starting result and restarts the walk over pieces; a
// piece completion updates the stored result and returns it. The block
// takes no new request while one is mid-update: each completion is
// a read-modify-write of the per-request result memory, read in one step
// and written in the next, and the walk state that decides the next request
// only settles with that write. Each result passes the second step's
// registers and the result queue on its way out. Two small queues,
// one behind the intake and one in front of the result port, let either
// side stall without stopping the other. Results of requests never preset
// are not defined; the memory has no clearing pass, so the block is ready
// straight out of reset. Configuration writes are taken on any cycle but
// belong to idle periods.
module io_completion_hole_merger #(
    parameter int REQUESTS   = 64,
    parameter int MAX_PIECES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request side
    input  logic                                push,
    output logic                                full,
    input  logic                                i_opcode,
    input  logic [ichm_pkg::IN_IDX_W-1:0]       i_request_index,
    input  logic signed [ichm_pkg::VALUE_W-1:0] i_preset_value,
    input  logic                                i_length_ok,
    input  logic [ichm_pkg::LEN_W-1:0]          i_returned_length,
    input  logic [ichm_pkg::LEN_W-1:0]          i_expected_length,
    input  logic                                i_chunk_missing,
    input  logic [ichm_pkg::CODE_W-1:0]         i_error_code,
    // result side
    output logic                                empty,
    input  logic                                pop,
    output logic [ichm_pkg::IN_IDX_W-1:0]       o_result_index,
    output logic signed [ichm_pkg::VALUE_W-1:0] o_result_value,
    output logic                                o_zero_fill,
    output logic [ichm_pkg::PIECE_W-1:0]        o_fill_first_piece,
    output logic [ichm_pkg::LEN_W-1:0]          o_fill_first_offset,
    output logic [ichm_pkg::PIECE_W-1:0]        o_fill_end_piece,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ichm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ichm_pkg::CODE_W-1:0]         i_cfg_data
);
    import ichm_pkg::*;

    t_cfg    r_cfg;
    t_work   work;
    logic    work_empty;
    logic    work_pop;
    t_result result;

    // Register writes never stall
    assign o_cfg_ready = 1'b1;

    // Hold configuration; writes to indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.read_mode   <= 1'b1;
            r_cfg.allow_holes <= 1'b0;
            r_cfg.hole_code   <= CODE_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_READ_MODE:   r_cfg.read_mode   <= i_cfg_data[0];
                CFG_ALLOW_HOLES: r_cfg.allow_holes <= i_cfg_data[0];
                CFG_HOLE_CODE:   r_cfg.hole_code   <= i_cfg_data;
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    // Intake: fold the index, classify the piece, queue the request
    ichm_front #(
        .REQUESTS (REQUESTS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_opcode          (i_opcode),
        .i_request_index   (i_request_index),
        .i_preset_value    (i_preset_value),
        .i_length_ok       (i_length_ok),
        .i_returned_length (i_returned_length),
        .i_expected_length (i_expected_length),
        .i_chunk_missing   (i_chunk_missing),
        .i_error_code      (i_error_code),
        .o_work            (work),
        .o_empty           (work_empty),
        .i_pop             (work_pop)
    );

    // Update engine: result memory, walk state, result queue
    ichm_back #(
        .REQUESTS   (REQUESTS),
        .MAX_PIECES (MAX_PIECES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_work       (work),
        .i_work_empty (work_empty),
        .o_work_pop   (work_pop),
        .o_result     (result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    // Unpack the oldest result onto the ports
    assign o_result_index      = result.idx;
    assign o_result_value      = result.value;
    assign o_zero_fill         = result.zero_fill;
    assign o_fill_first_piece  = result.first_piece;
    assign o_fill_first_offset = result.first_offset;
    assign o_fill_end_piece    = result.end_piece;

endmodule

@@ rtl/ichm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ichm_checker: port-level checks of the completion hole merger
// Tracks requests in flight against results delivered and checks the result
// port for consistency; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module ichm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                push,
    input logic                                full,
    input logic                                empty,
    input logic                                pop,
    input logic [ichm_pkg::IN_IDX_W-1:0]       o_result_index,
    input logic signed [ichm_pkg::VALUE_W-1:0] o_result_value,
    input logic                                o_zero_fill,
    input logic [ichm_pkg::PIECE_W-1:0]        o_fill_first_piece,
    input logic [ichm_pkg::LEN_W-1:0]          o_fill_first_offset,
    input logic [ichm_pkg::PIECE_W-1:0]        o_fill_end_piece
);
    import ichm_pkg::*;

    // Intake and result queues; a request mid-update holds a result queue slot
    localparam logic [3:0] MAX_IN_FLIGHT = 4'(2 * QUEUE_DEPTH);

    logic [3:0] r_in_flight;
    logic       in_take;
    logic       out_take;

    assign in_take  = push && !full;
    assign out_take = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= '0;
        end else begin
            case ({in_take, out_take})
                2'b10:   r_in_flight <= r_in_flight + 1'b1;
                2'b01:   r_in_flight <= r_in_flight - 1'b1;
                default: r_in_flight <= r_in_flight;
            endcase
        end
    end

    a_clean_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (empty && !full))
        else $error("result or intake queue not clear after reset");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_flight == '0) |-> empty)
        else $error("result offered with no request outstanding");

    a_bounded_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_flight <= MAX_IN_FLIGHT)
        else $error("more requests held than the buffers allow");

    a_fill_fields_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_zero_fill) |->
            (o_fill_first_piece == '0 && o_fill_first_offset == '0
             && o_fill_end_piece == '0))
        else $error("fill range reported without zero fill");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(o_result_index) && $stable(o_result_value)))
        else $error("waiting result changed before it was taken");

endmodule

bind io_completion_hole_merger ichm_checker u_checker (.*);
